// ===== src/keyframe_pose_interpolator_top_defines.svh =====
// ----------------------------------------------------------------------------
// keyframe pose interpolator assertion macros
// shared helpers for the port level checker
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSE_INTERPOLATOR_TOP_DEFINES_SVH
`define KEYFRAME_POSE_INTERPOLATOR_TOP_DEFINES_SVH

// same cycle implication, clocked on clk, off during reset
`define KFPI_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next cycle implication, clocked on clk, off during reset
`define KFPI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/kfpi_pkg.sv =====
// ----------------------------------------------------------------------------
// kfpi_pkg
// shared sizes, codes and request type of the keyframe pose interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package kfpi_pkg;

	localparam int MAX_FRAMES   = 64;
	localparam int MAX_ENTITIES = 16;

	localparam int FW     = $clog2(MAX_FRAMES);
	localparam int NW     = $clog2(MAX_FRAMES + 1);
	localparam int EIW    = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
	localparam int SW     = FW + EIW;
	localparam int SLOTS  = MAX_FRAMES * MAX_ENTITIES;
	localparam int DW     = FW + 16;
	localparam int BCW    = $clog2(DW + 1);
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [14:0] FULL_TURN = 15'd23040;
	localparam logic signed [25:0] FULL_TURN_S = 26'sd23040;
	localparam logic signed [25:0] HALF_TURN_S = 26'sd11520;
	localparam logic [6:0] NUM_FRAMES_RST = 7'd64;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_EXACT  = 2'd2;
	localparam logic [1:0] ST_INTERP = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic               ent_ok;
		logic [3:0]         entity_id;
		logic [15:0]        frame_whole;
		logic [7:0]         frame_fraction;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [14:0]        angle;
		logic [15:0]        scale;
	} kfpi_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic [14:0]        out_angle;
		logic [15:0]        out_scale;
	} kfpi_result_t;

endpackage

`default_nettype wire

// ===== src/kfpi_front.sv =====
// ----------------------------------------------------------------------------
// kfpi_front
// takes requests, checks the entity, reduces the angle, queues them
// ----------------------------------------------------------------------------
`default_nettype none

module kfpi_front import kfpi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [111:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	output logic             q_valid,
	output kfpi_item_t       q_item,
	input  wire logic        q_pop
);

	kfpi_item_t in_item;
	logic [14:0] ang_raw;
	kfpi_item_t q_mem [QDEPTH];
	logic [QPW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;
	logic push, pop;

	always_comb begin
		ang_raw                = s_tdata[90:76];
		in_item.mode           = s_tuser;
		in_item.entity_id      = s_tdata[3:0];
		in_item.ent_ok         = 32'(s_tdata[3:0]) < MAX_ENTITIES;
		in_item.frame_whole    = s_tdata[19:4];
		in_item.frame_fraction = s_tdata[27:20];
		in_item.pos_x          = s_tdata[51:28];
		in_item.pos_y          = s_tdata[75:52];
		in_item.angle          = (ang_raw >= FULL_TURN) ? ang_raw - FULL_TURN : ang_raw;
		in_item.scale          = s_tdata[106:91];
	end

	assign s_tready = cnt_q != QCW'(QDEPTH);
	assign q_valid  = cnt_q != '0;
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;
	assign q_item   = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/kfpi_back.sv =====
// ----------------------------------------------------------------------------
// kfpi_back
// sequencer: frame reduction, key search, t divide, blends, result register
// ----------------------------------------------------------------------------
`default_nettype none

module kfpi_back import kfpi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	input  wire logic        q_valid,
	input  wire kfpi_item_t  q_item,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,
	output logic [1:0]       m_tuser
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MOD  = 4'd1;
	localparam logic [3:0] S_UPD  = 4'd2;
	localparam logic [3:0] S_BACK = 4'd3;
	localparam logic [3:0] S_FWD  = 4'd4;
	localparam logic [3:0] S_RDA  = 4'd5;
	localparam logic [3:0] S_LDA  = 4'd6;
	localparam logic [3:0] S_LDB  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_TCL  = 4'd9;
	localparam logic [3:0] S_MUL  = 4'd10;
	localparam logic [3:0] S_ACC  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] state_q;
	logic [6:0] num_frames_q;
	logic [NW-1:0] n_len;
	kfpi_item_t it_q;
	logic [EIW-1:0] eidx;

	// key presence rows, one per entity, with a valid bit each
	logic [MAX_FRAMES-1:0] key_mem [MAX_ENTITIES];
	logic [MAX_FRAMES-1:0] key_rd_q, row, row_new;
	logic [MAX_ENTITIES-1:0] key_vld_q;

	// pose store: {scale, angle, y, x}
	logic [78:0] dat_mem [SLOTS];
	logic [78:0] dat_rd_q, dat_wr;
	logic [SW-1:0] dat_addr;
	logic dat_we, key_we;

	logic [BCW-1:0] bit_q;
	logic [NW-1:0] rem_q, rem_nx;
	logic [NW:0] rem_sh;
	logic [FW-1:0] base_q, f_q, fa_q, fb_q, f_dn, f_up, da, dk;
	logic [NW-1:0] cnt_q;
	logic hit;

	logic signed [23:0] xa_q, ya_q, xb_q, yb_q;
	logic [14:0] aa_q, ab_q;
	logic [15:0] ca_q, cb_q;

	logic [DW-1:0] dvd_q;
	logic [FW-1:0] drem_q, dvs_q;
	logic [FW:0] dsh;
	logic dge;
	logic [16:0] t_q;
	logic [1:0] j_q;

	logic signed [25:0] a_s, b_s, diff_s, d0;
	logic signed [17:0] t_s;
	logic signed [43:0] prod_q, acc_w;
	logic signed [25:0] acc_n;
	logic [14:0] ang_w;

	kfpi_result_t res_q;

	always_comb begin
		if (num_frames_q == '0) n_len = NW'(1);
		else if (32'(num_frames_q) > MAX_FRAMES) n_len = NW'(MAX_FRAMES);
		else n_len = NW'(num_frames_q);
	end

	assign eidx  = EIW'(it_q.entity_id);
	assign q_pop = state_q == S_IDLE;
	assign row   = key_vld_q[eidx] ? key_rd_q : '0;
	assign hit   = row[f_q];
	assign f_dn  = (f_q == '0) ? FW'(n_len - 1'b1) : f_q - 1'b1;
	assign f_up  = (f_q == FW'(n_len - 1'b1)) ? '0 : f_q + 1'b1;

	// frame reduction, one bit of frame_whole a step
	always_comb begin
		rem_sh = {rem_q, it_q.frame_whole[bit_q[3:0]]};
		rem_nx = (rem_sh >= {1'b0, n_len}) ? NW'(rem_sh - {1'b0, n_len}) : NW'(rem_sh);
	end

	// t divide, one quotient bit a step
	always_comb begin
		dsh = {drem_q, dvd_q[DW-1]};
		dge = dsh >= {1'b0, dvs_q};
	end

	assign da = (base_q >= fa_q) ? base_q - fa_q : FW'(NW'(base_q) + n_len - NW'(fa_q));
	assign dk = (fb_q >= fa_q) ? fb_q - fa_q : FW'(NW'(fb_q) + n_len - NW'(fa_q));

	always_comb begin
		row_new       = key_rd_q & {MAX_FRAMES{key_vld_q[eidx]}};
		row_new[base_q] = it_q.mode == MODE_WRITE;
	end

	assign key_we  = state_q == S_UPD && (it_q.mode == MODE_WRITE || it_q.mode == MODE_DELETE);
	assign dat_we  = state_q == S_UPD && it_q.mode == MODE_WRITE;
	assign dat_wr  = {it_q.scale, it_q.angle, it_q.pos_y, it_q.pos_x};

	always_comb begin
		unique case (state_q)
			S_UPD:   dat_addr = {base_q, eidx};
			S_RDA:   dat_addr = {fa_q, eidx};
			default: dat_addr = {fb_q, eidx};
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[eidx] <= row_new;
		key_rd_q <= key_mem[eidx];
		if (dat_we) dat_mem[dat_addr] <= dat_wr;
		dat_rd_q <= dat_mem[dat_addr];
	end

	// blend operands for the value picked by j_q
	always_comb begin
		d0 = '0;
		unique case (j_q)
			2'd0: begin
				a_s = 26'(xa_q);
				b_s = 26'(xb_q);
			end
			2'd1: begin
				a_s = 26'(ya_q);
				b_s = 26'(yb_q);
			end
			2'd2: begin
				a_s = 26'($signed({1'b0, aa_q}));
				b_s = 26'($signed({1'b0, ab_q}));
				d0  = b_s - a_s;
				if (d0 > HALF_TURN_S) b_s = b_s - FULL_TURN_S;
				else if (d0 < -HALF_TURN_S) b_s = b_s + FULL_TURN_S;
			end
			default: begin
				a_s = 26'($signed({1'b0, ca_q}));
				b_s = 26'($signed({1'b0, cb_q}));
			end
		endcase
		diff_s = b_s - a_s;
		t_s    = $signed({1'b0, t_q});
		acc_w  = 44'(a_s) + ((prod_q + 44'sd32768) >>> 16);
		acc_n  = 26'(acc_w);
		if (acc_n < 26'sd0) ang_w = 15'(acc_n + FULL_TURN_S);
		else if (acc_n >= FULL_TURN_S) ang_w = 15'(acc_n - FULL_TURN_S);
		else ang_w = 15'(acc_n);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				it_q  <= q_item;
				rem_q <= '0;
				bit_q <= BCW'(15);
			end
			S_MOD: begin
				rem_q  <= rem_nx;
				bit_q  <= bit_q - 1'b1;
				base_q <= FW'(rem_nx);
				f_q    <= FW'(rem_nx);
				cnt_q  <= '0;
				res_q  <= {((it_q.mode == MODE_QUERY) ? ST_NONE : ST_DONE), 79'd0};
			end
			S_BACK: begin
				if (hit) begin
					fa_q  <= f_q;
					f_q   <= base_q;
					cnt_q <= '0;
				end else begin
					f_q   <= f_dn;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_FWD: begin
				if (hit) fb_q <= f_q;
				f_q   <= f_up;
				cnt_q <= cnt_q + 1'b1;
			end
			S_LDA: begin
				xa_q <= dat_rd_q[23:0];
				ya_q <= dat_rd_q[47:24];
				aa_q <= dat_rd_q[62:48];
				ca_q <= dat_rd_q[78:63];
				res_q <= {ST_EXACT, dat_rd_q[23:0], dat_rd_q[47:24], dat_rd_q[62:48],
					dat_rd_q[78:63]};
			end
			S_LDB: begin
				xb_q   <= dat_rd_q[23:0];
				yb_q   <= dat_rd_q[47:24];
				ab_q   <= dat_rd_q[62:48];
				cb_q   <= dat_rd_q[78:63];
				dvd_q  <= {da, it_q.frame_fraction, 8'd0};
				drem_q <= '0;
				dvs_q  <= dk;
				bit_q  <= BCW'(DW - 1);
			end
			S_DIV: begin
				drem_q <= dge ? FW'(dsh - {1'b0, dvs_q}) : FW'(dsh);
				dvd_q  <= {dvd_q[DW-2:0], dge};
				bit_q  <= bit_q - 1'b1;
			end
			S_TCL: begin
				t_q <= (dvd_q > DW'(65536)) ? 17'h10000 : 17'(dvd_q);
				j_q <= 2'd0;
			end
			S_MUL: begin
				prod_q <= diff_s * t_s;
			end
			S_ACC: begin
				j_q <= j_q + 1'b1;
				unique case (j_q)
					2'd0: res_q.out_x <= 24'(acc_n);
					2'd1: res_q.out_y <= 24'(acc_n);
					2'd2: res_q.out_angle <= ang_w;
					default: begin
						res_q <= {ST_INTERP, res_q.out_x, res_q.out_y, res_q.out_angle,
							16'(acc_n)};
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_frames_q <= NUM_FRAMES_RST;
			key_vld_q    <= '0;
		end else begin
			if (cfg_we) num_frames_q <= cfg_wdata;
			if (key_we) key_vld_q[eidx] <= 1'b1;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_MOD;
				S_MOD: begin
					if (bit_q == '0) begin
						priority if (!it_q.ent_ok || it_q.mode == MODE_NOP) state_q <= S_OUT;
						else if (it_q.mode == MODE_QUERY) state_q <= S_BACK;
						else state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_OUT;
				S_BACK: begin
					if (hit) state_q <= S_FWD;
					else if (cnt_q == n_len - 1'b1) state_q <= S_OUT;
				end
				S_FWD: begin
					if (hit) state_q <= S_RDA;
					else if (cnt_q == n_len - 1'b1) state_q <= S_OUT;
				end
				S_RDA: state_q <= S_LDA;
				S_LDA: state_q <= (fa_q == fb_q) ? S_OUT : S_LDB;
				S_LDB: state_q <= S_DIV;
				S_DIV: if (bit_q == '0) state_q <= S_TCL;
				S_TCL: state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= (j_q == 2'd3) ? S_OUT : S_MUL;
				S_OUT: if (!m_tvalid || m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tuser <= res_q.status;
			m_tdata <= {1'b0, res_q.out_scale, res_q.out_angle, res_q.out_y, res_q.out_x};
		end
	end

endmodule

`default_nettype wire

// ===== src/keyframe_pose_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_top
// keyframe pose table with looping linear interpolation
// ----------------------------------------------------------------------------
// Requests are taken one at a time by a sequencer behind a two-entry queue,
// so the input keeps accepting while a result waits on the output register.
// A write or delete takes the request, reduces frame_whole modulo the loop
// length (one bit a cycle), does the read-modify-write of the entity's
// presence row and then loads the result. A query reduces the frame the same
// way, searches one frame a cycle, backward then forward (up to the loop length
// each way), reads the pose store and loads the result; an interpolation first
// runs a restoring divide for t, a clamp step and the blends of x, y, angle and
// scale through one shared 26x18 multiplier. Presence rows carry valid bits
// cleared at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_pose_interpolator_top import kfpi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// num_frames register write
	input  wire logic         cfg_we,
	input  wire logic [6:0]   cfg_wdata,
	// request channel
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// entity_id, frame_whole, frame_fraction, pos_x, pos_y, angle_in, scale_in
	input  wire logic [111:0] s_tdata,
	// mode
	input  wire logic [1:0]   s_tuser,
	// result channel
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_x, out_y, out_angle, out_scale
	output logic [79:0]       m_tdata,
	// status
	output logic [1:0]        m_tuser
);

	// queue between the classifying front and the sequencer
	logic       q_valid;
	logic       q_pop;
	kfpi_item_t q_item;

	kfpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// search, divide, blend and the result register
	kfpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== src/kfpi_checker.sv =====
// ----------------------------------------------------------------------------
// kfpi_checker
// port level checks on the result channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_pose_interpolator_top_defines.svh"

module kfpi_checker import kfpi_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	`KFPI_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`KFPI_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`KFPI_ASSERT_NOW(a_no_pose, m_tvalid && (m_tuser == ST_DONE || m_tuser == ST_NONE), m_tdata == '0, "pose not zero without keyframe")
	`KFPI_ASSERT_NOW(a_angle_rng, m_tvalid, m_tdata[62:48] < FULL_TURN, "angle out of range")

endmodule

bind keyframe_pose_interpolator_top kfpi_checker u_kfpi_checker (.*);

`default_nettype wire

// ===== sim/keyframe_pose_interpolator_top_tb.sv =====
// ----------------------------------------------------------------------------
// keyframe pose interpolator testbench
// drives write, delete and query requests with random bursts and output
// stalls, predicts each result from a local copy of the keyframe table and
// compares every field of every result in order
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_pose_interpolator_top_tb import kfpi_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TURN = 23040;
	localparam int HALF = 11520;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [111:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;
	logic [1:0] m_tuser;

	keyframe_pose_interpolator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// local copy of the keyframe table and loop length
	logic key_seen [SLOTS];
	logic signed [23:0] key_x [SLOTS];
	logic signed [23:0] key_y [SLOTS];
	logic [14:0] key_angle [SLOTS];
	logic [15:0] key_scale [SLOTS];
	logic [6:0] loop_reg;

	kfpi_result_t pending_poses[$];
	int error_count;
	longint cycle_count;
	logic hold_off;     // long receiver stall
	int burst_max;      // 0 means send back to back
	int stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[keyframe_pose_interpolator_top] ERROR");
			$finish;
		end
	end

	// a + round((b - a) * t / 65536), rounding half up
	function automatic longint blend_q16(longint a, longint b, longint t);
		longint p;
		longint q;
		p = (b - a) * t + 32768;
		if (p >= 0) q = p / 65536;
		else q = -((-p + 65535) / 65536);
		return a + q;
	endfunction

	// compute the expected result of one request and update the table
	function automatic kfpi_result_t predict_pose(logic [1:0] mode, logic [3:0] ent,
			logic [15:0] whole, logic [7:0] frac, logic signed [23:0] px,
			logic signed [23:0] py, logic [14:0] ang, logic [15:0] sc);
		kfpi_result_t r;
		int n, b, fa, fb, i, f, sa, sb;
		bit ha, hb;
		longint d, k, t, aa, ab, an;
		r = '0;
		n = (loop_reg == 0) ? 1 : (loop_reg > MAX_FRAMES) ? MAX_FRAMES : int'(loop_reg);
		b = int'(whole) % n;
		if (mode == MODE_WRITE) begin
			sa = b * MAX_ENTITIES + ent;
			key_seen[sa] = 1'b1;
			key_x[sa] = px;
			key_y[sa] = py;
			key_angle[sa] = 15'(int'(ang) % TURN);
			key_scale[sa] = sc;
			return r;
		end
		if (mode == MODE_DELETE) begin
			key_seen[b * MAX_ENTITIES + ent] = 1'b0;
			return r;
		end
		if (mode == MODE_NOP) return r;
		ha = 0;
		hb = 0;
		fa = b;
		fb = b;
		for (i = 0; i < n && !ha; i++) begin
			f = (b + n - i) % n;
			if (key_seen[f * MAX_ENTITIES + ent]) begin
				fa = f;
				ha = 1;
			end
		end
		for (i = 0; i < n && !hb; i++) begin
			f = (b + i) % n;
			if (key_seen[f * MAX_ENTITIES + ent]) begin
				fb = f;
				hb = 1;
			end
		end
		if (!ha || !hb) begin
			r.status = ST_NONE;
			return r;
		end
		sa = fa * MAX_ENTITIES + ent;
		sb = fb * MAX_ENTITIES + ent;
		if (fa == fb) begin
			r.status = ST_EXACT;
			r.out_x = key_x[sa];
			r.out_y = key_y[sa];
			r.out_angle = key_angle[sa];
			r.out_scale = key_scale[sa];
			return r;
		end
		d = longint'((b + n - fa) % n) * 256 + frac;
		k = longint'((fb + n - fa) % n) * 256;
		t = (d * 65536) / k;
		if (t > 65536) t = 65536;
		aa = key_angle[sa];
		ab = key_angle[sb];
		if (ab - aa > HALF) ab -= TURN;
		else if (ab - aa < -HALF) ab += TURN;
		an = blend_q16(aa, ab, t) % TURN;
		if (an < 0) an += TURN;
		r.status = ST_INTERP;
		r.out_x = 24'(blend_q16(key_x[sa], key_x[sb], t));
		r.out_y = 24'(blend_q16(key_y[sa], key_y[sb], t));
		r.out_angle = 15'(an);
		r.out_scale = 16'(blend_q16(key_scale[sa], key_scale[sb], t));
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		kfpi_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected result", m_tuser, 0);
			end else begin
				want = pending_poses.pop_front();
				if (m_tuser != want.status) report_mismatch("status", m_tuser, want.status);
				if (m_tdata[23:0] != want.out_x) report_mismatch("out_x", m_tdata[23:0], want.out_x);
				if (m_tdata[47:24] != want.out_y)
					report_mismatch("out_y", m_tdata[47:24], want.out_y);
				if (m_tdata[62:48] != want.out_angle)
					report_mismatch("out_angle", m_tdata[62:48], want.out_angle);
				if (m_tdata[78:63] != want.out_scale)
					report_mismatch("out_scale", m_tdata[78:63], want.out_scale);
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// send one request, with burst gaps ahead of it
	task automatic send_request(logic [1:0] mode, logic [3:0] ent, logic [15:0] whole,
			logic [7:0] frac, logic signed [23:0] px, logic signed [23:0] py,
			logic [14:0] ang, logic [15:0] sc);
		int gap;
		gap = 0;
		if (burst_max > 0 && $urandom_range(burst_max) == 0) gap = $urandom_range(12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'd0, sc, ang, py, px, frac, whole, ent};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_poses.push_back(predict_pose(mode, ent, whole, frac, px, py, ang, sc));
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		while (pending_poses.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_loop_length(logic [6:0] value);
		go_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		loop_reg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_key(int ent, int frame, int px, int py, int ang, int sc);
		send_request(MODE_WRITE, 4'(ent), 16'(frame), 8'd0, 24'(px), 24'(py), 15'(ang), 16'(sc));
	endtask

	task automatic query_pose(int ent, int frame, int frac);
		send_request(MODE_QUERY, 4'(ent), 16'(frame), 8'(frac), 24'($urandom), 24'($urandom),
			15'($urandom), 16'($urandom));
	endtask

	// random request: mostly writes and queries into a small entity set
	task automatic random_request(int nframes);
		int pick;
		logic [15:0] whole;
		pick = $urandom_range(99);
		whole = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(nframes + 2));
		if (pick < 35)
			send_request(MODE_WRITE, 4'($urandom_range(3)), whole, 8'($urandom),
				24'($urandom), 24'($urandom), 15'($urandom_range(32767)), 16'($urandom));
		else if (pick < 45)
			send_request(MODE_DELETE, 4'($urandom), whole, 8'($urandom), 24'($urandom),
				24'($urandom), 15'($urandom), 16'($urandom));
		else if (pick < 48)
			send_request(MODE_NOP, 4'($urandom), 16'($urandom), 8'($urandom), 24'($urandom),
				24'($urandom), 15'($urandom), 16'($urandom));
		else
			query_pose(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(3),
				whole, $urandom_range(255));
	endtask

	// extremes of fields, exact, single key, angle wrap both ways, clamping
	task automatic test_directed();
		query_pose(0, 0, 0);
		write_key(0, 5, 8388607, -8388608, 23039, 65535);
		query_pose(0, 5, 255);
		query_pose(0, 40, 17);
		write_key(0, 10, -8388608, 8388607, 100, 0);
		query_pose(0, 7, 128);
		query_pose(0, 9, 255);
		query_pose(0, 30, 0);
		send_request(MODE_WRITE, 4'd15, 16'hffff, 8'hff, 24'h555555, 24'haaaaaa, 15'h7fff, 16'h1);
		query_pose(15, 65535, 255);
		write_key(1, 0, 0, 0, 200, 256);
		write_key(1, 3, 256, -256, 23000, 512);
		query_pose(1, 1, 64);
		query_pose(1, 2, 200);
		write_key(1, 0, 0, 0, 22000, 256);
		write_key(1, 3, 0, 0, 300, 256);
		query_pose(1, 1, 1);
		send_request(MODE_DELETE, 4'd1, 16'd3, 8'd0, 24'd0, 24'd0, 15'd0, 16'd0);
		send_request(MODE_DELETE, 4'd1, 16'd3, 8'd0, 24'd0, 24'd0, 15'd0, 16'd0);
		query_pose(1, 2, 7);
		send_request(MODE_NOP, 4'd2, 16'd2, 8'd9, 24'd1, 24'd1, 15'd1, 16'd1);
		query_pose(2, 3, 3);
	endtask

	task automatic test_loop_lengths();
		logic [6:0] lengths [6];
		lengths = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd13};
		foreach (lengths[j]) begin
			set_loop_length(lengths[j]);
			repeat (30) random_request(8);
			query_pose(0, 63, 255);
		end
	endtask

	task automatic test_random(int count);
		burst_max = 0;
		stall_pct = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				burst_max = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 8);
				stall_pct = $urandom_range(3) == 0 ? 0 : $urandom_range(70);
			end
			random_request(loop_reg == 0 ? 1 : int'(loop_reg));
		end
	endtask

	// receiver holds off a long time while requests keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (12) random_request(16);
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		hold_off = 1'b0;
		burst_max = 3;
		stall_pct = 30;
		error_count = 0;
		cycle_count = 0;
		loop_reg = NUM_FRAMES_RST;
		for (int i = 0; i < SLOTS; i++) key_seen[i] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		set_loop_length(7'd20);
		test_random(700);
		test_loop_lengths();
		set_loop_length(7'd64);
		test_random(800);
		set_loop_length(7'd5);
		test_random(200);

		go_idle();
		if (error_count == 0) begin
			$display("[keyframe_pose_interpolator_top] OK");
		end else begin
			$display("[keyframe_pose_interpolator_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
